FILE: src/runlist_decoder_assert.svh
// Assertion macros used by the run list decoder checker.
// Each macro expands to one labeled concurrent assertion clocked on clock.
`ifndef RUNLIST_DECODER_ASSERT_SVH
`define RUNLIST_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RLD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RLD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/rld_pkg.sv
// Shared types and constants for the run list decoder.
// No dependencies; imported by the decoder and its checker.
`default_nettype none

package rld_pkg;

   localparam int RUN_BYTE_W   = 8;
   localparam int SECTOR_W     = 64;
   localparam int SPC_W        = 8;
   localparam int REQ_DATA_W   = 8;
   localparam int RSP_DATA_W   = 128;
   localparam int RSP_USER_W   = 3;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 64;
   localparam int ERR_W        = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SECTORS_PER_CLUSTER = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_SECTOR         = 1'd1;

   localparam logic [SPC_W-1:0] SPC_RESET = 8'd8;

   localparam logic [ERR_W-1:0] ERR_OK         = 2'd0;
   localparam logic [ERR_W-1:0] ERR_FIELD_SIZE = 2'd1;
   localparam logic [ERR_W-1:0] ERR_NEG_POS    = 2'd2;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW   = 2'd3;

   localparam logic [3:0] NIBBLE_MASK = 4'hf;
   localparam logic [7:0] SIGN_BIT    = 8'h80;

   typedef enum logic [3:0] {
      PH_HEADER = 4'b0001,
      PH_LENGTH = 4'b0010,
      PH_DELTA  = 4'b0100,
      PH_SKIP   = 4'b1000
   } phase_type;

   // Job leaving the parse stage.
   typedef struct packed {
      logic                eol;
      logic                bad;
      logic                sparse;
      logic                neg;
      logic [SECTOR_W-1:0] length;
      logic [SECTOR_W-1:0] position;
   } parse_job_type;

   // Job leaving the scale stage.
   typedef struct packed {
      logic                eol;
      logic                bad;
      logic                sparse;
      logic                neg;
      logic                cnt_ovf;
      logic                pos_ovf;
      logic [SECTOR_W-1:0] count;
      logic [SECTOR_W-1:0] pos_scaled;
   } scale_job_type;

endpackage

`default_nettype wire

FILE: src/runlist_decoder.sv
// Run list decoder: parses a file-system data run list one byte per cycle and
// returns start sector and sector count per run. Depends on rld_pkg.
// Takes one byte per cycle while req_tready is high, with no dead cycles between
// runs or lists. A result passes to rsp_ after the transfer of the byte that
// closes its run (header for a terminator or bad header, last length byte of a
// sparse run, last delta byte otherwise) through the parse register, scaling
// multiply register and base add register. Position, delta and length decode in
// the parse stage, so back-to-back runs never wait on each other. Input
// transfers continue while a result waits on rsp_ as long as one of the two
// inner stages is free. Configuration is applied as written and must only
// change while no result is pending. There is no clearing pass after reset.
`default_nettype none

module runlist_decoder #(
   parameter int FIELD_BYTES = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   input  wire logic [rld_pkg::REQ_DATA_W-1:0]  req_tdata,   // [7:0] run_byte
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   output      logic [rld_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [63:0] start_sector,
                                                             // [127:64] sector_count
   output      logic                            rsp_tlast,   // end_of_list
   output      logic [rld_pkg::RSP_USER_W-1:0]  rsp_tuser,   // [0] is_sparse,
                                                             // [2:1] error_code
   input  wire logic                            csr_we,
   input  wire logic [rld_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [rld_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rld_pkg::*;

   localparam int ACC_W = 8 * FIELD_BYTES;
   localparam int IDX_W = (FIELD_BYTES > 1) ? $clog2(FIELD_BYTES) : 1;
   localparam logic [3:0] MAX_FIELD = 4'(FIELD_BYTES);

   logic [SPC_W-1:0]    spc_ff, spc_in;
   logic [SECTOR_W-1:0] base_ff, base_in;

   phase_type           phase_ff, phase_in;
   logic [3:0]          len_left_ff, len_left_in;
   logic [3:0]          delta_left_ff, delta_left_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [ACC_W-1:0]    len_acc_ff, len_acc_in;
   logic [ACC_W-1:0]    delta_acc_ff, delta_acc_in;
   logic [SECTOR_W-1:0] pos_ff, pos_in;

   logic                j1_v_ff, j1_v_in;
   parse_job_type       j1_ff, j1_in;
   logic                j2_v_ff, j2_v_in;
   scale_job_type       j2_ff, j2_in;
   logic                out_v_ff, out_v_in;
   logic [SECTOR_W-1:0] start_ff, start_in;
   logic [SECTOR_W-1:0] count_ff, count_in;
   logic                sparse_ff, sparse_in;
   logic                eol_ff, eol_in;
   logic [ERR_W-1:0]    err_ff, err_in;

   logic                out_load, j2_load, j1_load, accept;
   logic [RUN_BYTE_W-1:0] run_byte;
   logic [3:0]          hdr_len, hdr_off;
   logic [ACC_W-1:0]    len_merged, delta_merged;
   logic [SECTOR_W-1:0] delta_ext, pos_sum;
   logic                emit;
   parse_job_type       job;

   logic [SECTOR_W+SPC_W-1:0] cnt_prod, pos_prod;
   logic [SECTOR_W:0]         start_sum;
   logic                      start_ovf;

   // pipeline advance
   assign out_load   = !out_v_ff || rsp_tready;
   assign j2_load    = !j2_v_ff || out_load;
   assign j1_load    = !j1_v_ff || j2_load;
   assign req_tready = j1_load;
   assign accept     = req_tvalid && req_tready;

   assign run_byte = req_tdata[RUN_BYTE_W-1:0];
   assign hdr_len  = run_byte[3:0] & NIBBLE_MASK;
   assign hdr_off  = run_byte[7:4] & NIBBLE_MASK;

   always_comb begin
      for (int k = 0; k < FIELD_BYTES; k++) begin
         if (IDX_W'(k) < idx_ff) begin
            len_merged[8*k +: 8]   = len_acc_ff[8*k +: 8];
            delta_merged[8*k +: 8] = delta_acc_ff[8*k +: 8];
         end else if (IDX_W'(k) == idx_ff) begin
            len_merged[8*k +: 8]   = run_byte;
            delta_merged[8*k +: 8] = run_byte;
         end else begin
            len_merged[8*k +: 8]   = '0;
            delta_merged[8*k +: 8] = ((run_byte & SIGN_BIT) != '0) ? 8'hff : 8'h00;
         end
      end
   end

   assign delta_ext = SECTOR_W'($signed(delta_merged));
   assign pos_sum   = pos_ff + delta_ext;

   always_comb begin
      spc_in  = spc_ff;
      base_in = base_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SECTORS_PER_CLUSTER: spc_in  = csr_wdata[SPC_W-1:0];
            CSR_BASE_SECTOR:         base_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // parse stage
   always_comb begin
      phase_in      = phase_ff;
      len_left_in   = len_left_ff;
      delta_left_in = delta_left_ff;
      idx_in        = idx_ff;
      len_acc_in    = len_acc_ff;
      delta_acc_in  = delta_acc_ff;
      pos_in        = pos_ff;
      emit          = 1'b0;
      job           = '0;
      if (accept) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (run_byte == '0) begin
                  pos_in  = '0;
                  emit    = 1'b1;
                  job.eol = 1'b1;
               end else begin
                  len_left_in   = hdr_len;
                  delta_left_in = hdr_off;
                  idx_in        = '0;
                  if (hdr_len == '0 || hdr_len > MAX_FIELD || hdr_off > MAX_FIELD) begin
                     phase_in = PH_SKIP;
                     emit     = 1'b1;
                     job.bad  = 1'b1;
                  end else begin
                     phase_in = PH_LENGTH;
                  end
               end
            end
            PH_LENGTH: begin
               len_acc_in  = len_merged;
               idx_in      = idx_ff + 1'b1;
               len_left_in = len_left_ff - 1'b1;
               if (len_left_ff == 4'd1) begin
                  idx_in = '0;
                  if (delta_left_ff == '0) begin
                     phase_in   = PH_HEADER;
                     emit       = 1'b1;
                     job.sparse = 1'b1;
                     job.length = SECTOR_W'(len_merged);
                  end else begin
                     phase_in = PH_DELTA;
                  end
               end
            end
            PH_DELTA: begin
               delta_acc_in  = delta_merged;
               idx_in        = idx_ff + 1'b1;
               delta_left_in = delta_left_ff - 1'b1;
               if (delta_left_ff == 4'd1) begin
                  idx_in       = '0;
                  pos_in       = pos_sum;
                  phase_in     = PH_HEADER;
                  emit         = 1'b1;
                  job.neg      = pos_sum[SECTOR_W-1];
                  job.length   = SECTOR_W'(len_acc_ff);
                  job.position = pos_sum;
               end
            end
            PH_SKIP: begin
               if (len_left_ff != '0) begin
                  len_left_in = len_left_ff - 1'b1;
               end else if (delta_left_ff != '0) begin
                  delta_left_in = delta_left_ff - 1'b1;
               end
               if (len_left_in == '0 && delta_left_in == '0) begin
                  phase_in = PH_HEADER;
               end
            end
            default: phase_in = PH_HEADER;
         endcase
      end
   end

   always_comb begin
      j1_v_in = j1_v_ff;
      j1_in   = j1_ff;
      if (j1_load) begin
         j1_v_in = emit;
         j1_in   = job;
      end
   end

   // scale stage
   assign cnt_prod = j1_ff.length * spc_ff;
   assign pos_prod = j1_ff.position * spc_ff;

   always_comb begin
      j2_v_in = j2_v_ff;
      j2_in   = j2_ff;
      if (j2_load) begin
         j2_v_in          = j1_v_ff;
         j2_in.eol        = j1_ff.eol;
         j2_in.bad        = j1_ff.bad;
         j2_in.sparse     = j1_ff.sparse;
         j2_in.neg        = j1_ff.neg;
         j2_in.cnt_ovf    = cnt_prod[SECTOR_W +: SPC_W] != '0;
         j2_in.pos_ovf    = pos_prod[SECTOR_W +: SPC_W] != '0;
         j2_in.count      = (cnt_prod[SECTOR_W +: SPC_W] != '0) ? '1
                                                                : cnt_prod[SECTOR_W-1:0];
         j2_in.pos_scaled = pos_prod[SECTOR_W-1:0];
      end
   end

   // base add and result stage
   assign start_sum = {1'b0, base_ff} + {1'b0, j2_ff.pos_scaled};
   assign start_ovf = j2_ff.pos_ovf || start_sum[SECTOR_W];

   always_comb begin
      out_v_in  = out_v_ff;
      start_in  = start_ff;
      count_in  = count_ff;
      sparse_in = sparse_ff;
      eol_in    = eol_ff;
      err_in    = err_ff;
      if (out_load) begin
         out_v_in  = j2_v_ff;
         start_in  = '0;
         count_in  = j2_ff.count;
         sparse_in = 1'b0;
         eol_in    = 1'b0;
         err_in    = ERR_OK;
         if (j2_ff.eol) begin
            count_in = '0;
            eol_in   = 1'b1;
         end else if (j2_ff.bad) begin
            count_in = '0;
            err_in   = ERR_FIELD_SIZE;
         end else if (j2_ff.sparse) begin
            sparse_in = 1'b1;
            err_in    = j2_ff.cnt_ovf ? ERR_OVERFLOW : ERR_OK;
         end else if (j2_ff.neg) begin
            err_in = ERR_NEG_POS;
         end else begin
            start_in = start_ovf ? '1 : start_sum[SECTOR_W-1:0];
            err_in   = (j2_ff.cnt_ovf || start_ovf) ? ERR_OVERFLOW : ERR_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spc_ff        <= SPC_RESET;
         base_ff       <= '0;
         phase_ff      <= PH_HEADER;
         len_left_ff   <= '0;
         delta_left_ff <= '0;
         idx_ff        <= '0;
         pos_ff        <= '0;
         j1_v_ff       <= 1'b0;
         j2_v_ff       <= 1'b0;
         out_v_ff      <= 1'b0;
      end else begin
         spc_ff        <= spc_in;
         base_ff       <= base_in;
         phase_ff      <= phase_in;
         len_left_ff   <= len_left_in;
         delta_left_ff <= delta_left_in;
         idx_ff        <= idx_in;
         pos_ff        <= pos_in;
         j1_v_ff       <= j1_v_in;
         j2_v_ff       <= j2_v_in;
         out_v_ff      <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      len_acc_ff   <= len_acc_in;
      delta_acc_ff <= delta_acc_in;
      j1_ff        <= j1_in;
      j2_ff        <= j2_in;
      start_ff     <= start_in;
      count_ff     <= count_in;
      sparse_ff    <= sparse_in;
      eol_ff       <= eol_in;
      err_ff       <= err_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {count_ff, start_ff};
   assign rsp_tlast  = eol_ff;
   assign rsp_tuser  = {err_ff, sparse_ff};

endmodule

`default_nettype wire

FILE: src/rld_checker.sv
// Port-level checker for the run list decoder, bound to its top level.
// Depends on rld_pkg and runlist_decoder_assert.svh.
`default_nettype none
`include "runlist_decoder_assert.svh"

module rld_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [rld_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input wire logic                            rsp_tlast,
   input wire logic [rld_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   import rld_pkg::*;

   logic [ERR_W-1:0]                   err;
   logic [RSP_DATA_W+RSP_USER_W:0]     rsp_word;
   logic                               rsp_wait;
   logic                               eol_out;
   logic                               bad_out;
   logic                               sparse_out;
   logic                               sparse_ok;

   assign err        = rsp_tuser[2:1];
   assign rsp_word   = {rsp_tlast, rsp_tuser, rsp_tdata};
   assign rsp_wait   = rsp_tvalid && !rsp_tready;
   assign eol_out    = rsp_tvalid && rsp_tlast;
   assign bad_out    = rsp_tvalid && (err == ERR_FIELD_SIZE);
   assign sparse_out = rsp_tvalid && rsp_tuser[0];
   assign sparse_ok  = (rsp_tdata[SECTOR_W-1:0] == '0) && !rsp_tlast
                       && ((err == ERR_OK) || (err == ERR_OVERFLOW));

   `RLD_ASSERT_NEXT(a_rsp_hold, rsp_wait, rsp_tvalid && $stable(rsp_word), "rsp held badly")

   `RLD_ASSERT_NOW(a_eol_clean, eol_out, rsp_tdata == '0 && rsp_tuser == '0, "end of list not clean")

   `RLD_ASSERT_NOW(a_bad_clean, bad_out, {rsp_tlast, rsp_tuser[0], rsp_tdata} == '0, "bad size not clean")

   `RLD_ASSERT_NOW(a_sparse_start, sparse_out, sparse_ok, "sparse run not clean")

endmodule

bind runlist_decoder rld_checker u_rld_checker (.*);

`default_nettype wire
